>>> rtl/rrss_pkg.sv
// Shared types and constants for the round-robin sleep scheduler.
// Used by rrss_alu and round_robin_sleep_scheduler; no dependencies.
`default_nettype none
package rrss_pkg;

   localparam int MAX_SLOTS_DEF = 8;
   localparam int TIME_W        = 32;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int SLOT_W        = 3;

   localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
   localparam logic [OP_W-1:0] OP_SLEEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE_READY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_req_type;

endpackage
`default_nettype wire

>>> rtl/round_robin_sleep_scheduler.sv
// Round-robin thread scheduler with per-slot sleep timers.
// Depends on rrss_pkg and rrss_alu.
//
// One request beat is taken at a time; req_stall stays high until its result
// is parked for the output register. Create, sleep and unused codes go from
// idle straight to the done state. A pick visits slots in turn: a ready slot
// ends the walk, a sleeping one needs a wake-time memory read, then the due
// compare on the shared adder. The result register lets the next request
// enter while a result still waits on rsp_stall.
`default_nettype none
module round_robin_sleep_scheduler #(
   parameter int MAX_SLOTS = rrss_pkg::MAX_SLOTS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire [rrss_pkg::OP_W-1:0]          req_op,
   input  wire [rrss_pkg::TIME_W-1:0]        req_now_ms,
   input  wire [rrss_pkg::TIME_W-1:0]        req_sleep_ms,
   input  wire [rrss_pkg::SLOT_W-1:0]        req_thread_id,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [rrss_pkg::STATUS_W-1:0]     rsp_status,
   output logic [rrss_pkg::SLOT_W-1:0]       rsp_thread_slot,
   output logic                              rsp_switch_request
);
   import rrss_pkg::*;

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int TW = (CW > SLOT_W) ? CW : SLOT_W;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          last_ff, last_in;
   logic                   none_ff, none_in;
   logic [CW-1:0]          visit_ff, visit_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [MAX_SLOTS-1:0]   sleep_ff, sleep_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [IW-1:0]          res_slot_ff, res_slot_in;
   logic                   res_sw_ff, res_sw_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic                   rsp_sw_ff;

   logic [TIME_W-1:0]      wake_mem [MAX_SLOTS];
   logic [TIME_W-1:0]      rd_ff;
   logic                   mem_we;
   logic [IW-1:0]          mem_wa;
   logic [IW-1:0]          mem_ra;

   alu_req_type            alu_req;
   logic [TIME_W-1:0]      alu_sum;
   logic                   alu_carry;

   logic                   accept;
   logic                   load_out;
   logic [TW-1:0]          tid_w;
   logic [CW-1:0]          inc;
   logic [IW-1:0]          nidx;
   logic [TW-1:0]          res_slot_w;

   rrss_alu u_alu (
      .req   (alu_req),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign load_out = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign tid_w    = TW'(req_thread_id);
   assign inc      = CW'(last_ff) + CW'(1);
   assign nidx     = (none_ff || inc >= count_ff) ? '0 : inc[IW-1:0];
   assign res_slot_w = TW'(res_slot_ff);

   always_comb begin
      alu_req.sub = (state_ff != S_IDLE);
      alu_req.a   = (state_ff == S_IDLE) ? req_now_ms : now_ff;
      alu_req.b   = (state_ff == S_IDLE) ? req_sleep_ms : rd_ff;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      none_in       = none_ff;
      visit_in      = visit_ff;
      now_in        = now_ff;
      sleep_in      = sleep_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_sw_in     = res_sw_ff;
      mem_we        = 1'b0;
      mem_wa        = tid_w[IW-1:0];
      mem_ra        = nidx;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in        = req_now_ms;
               visit_in      = '0;
               res_status_in = ST_OK;
               res_slot_in   = '0;
               res_sw_in     = 1'b0;
               state_in      = S_DONE;
               case (req_op)
                  OP_CREATE: begin
                     if (count_ff >= CW'(MAX_SLOTS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        sleep_in[count_ff[IW-1:0]] = 1'b0;
                        count_in    = count_ff + CW'(1);
                        res_slot_in = count_ff[IW-1:0];
                     end
                  end
                  OP_SLEEP: begin
                     if (tid_w >= TW'(count_ff)) begin
                        res_status_in = ST_NOT_IN_USE;
                     end else begin
                        mem_we                  = 1'b1;
                        sleep_in[tid_w[IW-1:0]] = 1'b1;
                        res_sw_in               = 1'b1;
                     end
                  end
                  OP_PICK: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NONE_READY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            last_in  = nidx;
            none_in  = 1'b0;
            visit_in = visit_ff + CW'(1);
            if (!sleep_ff[nidx]) begin
               res_slot_in = nidx;
               state_in    = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (alu_carry) begin
               sleep_in[last_ff] = 1'b0;
               res_slot_in       = last_ff;
               state_in          = S_DONE;
            end else if (visit_ff == count_ff) begin
               res_status_in = ST_NONE_READY;
               state_in      = S_DONE;
            end else begin
               state_in = S_WALK;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         none_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         none_ff      <= none_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      visit_ff      <= visit_in;
      now_ff        <= now_in;
      sleep_ff      <= sleep_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_sw_ff     <= res_sw_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_w[SLOT_W-1:0];
         rsp_sw_ff     <= res_sw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wake_mem[mem_wa] <= alu_sum;
      end
      rd_ff <= wake_mem[mem_ra];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_thread_slot    = rsp_slot_ff;
   assign rsp_switch_request = rsp_sw_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SLOTS))
      else $error("slot count beyond table size");

   a_cmp_sleeper: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> sleep_ff[last_ff])
      else $error("due compare on a slot that is not sleeping");

   a_walk_from_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && $past(state_ff) == S_IDLE) |-> (count_ff != '0))
      else $error("walk started on an empty table");

   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_switch_request || rsp_status != ST_OK)) |-> (rsp_thread_slot == '0))
      else $error("slot field set on a sleep or failed beat");

endmodule
`default_nettype wire

>>> rtl/rrss_alu.sv
// Shared 32-bit add/subtract unit: wake-time sum and due compare.
// Depends on rrss_pkg.
`default_nettype none
module rrss_alu (
   input  var rrss_pkg::alu_req_type            req,
   output logic [rrss_pkg::TIME_W-1:0]          sum,
   output logic                                 carry
);
   import rrss_pkg::*;

   logic [TIME_W:0] total;

   assign total = {1'b0, req.a} + {1'b0, req.b ^ {TIME_W{req.sub}}} + (TIME_W+1)'(req.sub);
   assign sum   = total[TIME_W-1:0];
   assign carry = total[TIME_W];

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for round_robin_sleep_scheduler: directed and random beats,
// predicted by a slot-table model in the bench, with random request gaps and response stalls.
// Depends on rrss_pkg and the scheduler RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rrss_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AFTER = 200;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [TIME_W-1:0]   now_ms;
      logic [TIME_W-1:0]   sleep_ms;
      logic [SLOT_W-1:0]   thread_id;
   } sched_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   thread_slot;
      logic                switch_request;
   } sched_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op = OP_CREATE;
   logic [TIME_W-1:0]   req_now_ms = '0;
   logic [TIME_W-1:0]   req_sleep_ms = '0;
   logic [SLOT_W-1:0]   req_thread_id = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_thread_slot;
   logic                rsp_switch_request;

   sched_req_type pending_beats[$];
   sched_rsp_type expected_results[$];

   int  sched_count = 0;
   logic sched_sleeping[MAX_SLOTS_DEF];
   logic [TIME_W-1:0] sched_wake_at[MAX_SLOTS_DEF];
   int  sched_last = 0;
   bit  sched_pointer_none = 1'b1;

   int  cycle_count = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   logic [TIME_W-1:0] sim_now = '0;
   sched_rsp_type want;

   round_robin_sleep_scheduler uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_now_ms         (req_now_ms),
      .req_sleep_ms       (req_sleep_ms),
      .req_thread_id      (req_thread_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_thread_slot    (rsp_thread_slot),
      .rsp_switch_request (rsp_switch_request)
   );

   always #5 clock = ~clock;

   function automatic sched_rsp_type predict_schedule(input sched_req_type b);
      sched_rsp_type r;
      int idx;
      int i;
      bit found;
      r = '0;
      found = 1'b0;
      case (b.op)
         OP_CREATE: begin
            if (sched_count >= MAX_SLOTS_DEF) begin
               r.status = ST_FULL;
            end else begin
               sched_sleeping[sched_count] = 1'b0;
               sched_wake_at[sched_count] = '0;
               r.status = ST_OK;
               r.thread_slot = SLOT_W'(sched_count);
               sched_count++;
            end
         end
         OP_SLEEP: begin
            if (b.thread_id >= sched_count) begin
               r.status = ST_NOT_IN_USE;
            end else begin
               sched_wake_at[b.thread_id] = b.now_ms + b.sleep_ms;
               sched_sleeping[b.thread_id] = 1'b1;
               r.status = ST_OK;
               r.switch_request = 1'b1;
            end
         end
         OP_PICK: begin
            r.status = ST_NONE_READY;
            idx = sched_last;
            for (i = 0; i < sched_count && !found; i++) begin
               if (sched_pointer_none) begin
                  idx = 0;
                  sched_pointer_none = 1'b0;
               end else begin
                  idx = (idx + 1 >= sched_count) ? 0 : idx + 1;
               end
               sched_last = idx;
               if (sched_sleeping[idx] && b.now_ms >= sched_wake_at[idx])
                  sched_sleeping[idx] = 1'b0;
               if (!sched_sleeping[idx]) begin
                  found = 1'b1;
                  r.status = ST_OK;
                  r.thread_slot = SLOT_W'(idx);
               end
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones, and a recurring quiet stretch with none
   function automatic int draw_idle();
      int r;
      if ((cycle_count / 256) % 4 == 3)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_beat(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_ms,
                            input logic [TIME_W-1:0] sleep_ms,
                            input logic [SLOT_W-1:0] thread_id);
      sched_req_type b;
      b.op = op;
      b.now_ms = now_ms;
      b.sleep_ms = sleep_ms;
      b.thread_id = thread_id;
      pending_beats.push_back(b);
   endtask

   task automatic offer_front();
      req_op <= pending_beats[0].op;
      req_now_ms <= pending_beats[0].now_ms;
      req_sleep_ms <= pending_beats[0].sleep_ms;
      req_thread_id <= pending_beats[0].thread_id;
      req_valid <= 1'b1;
      gap_left = draw_idle();
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic fill_random(input int count);
      int made;
      int k;
      int r;
      logic [OP_W-1:0] op;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] dur;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            // put every slot to sleep, then pick as time moves on
            for (k = 0; k < MAX_SLOTS_DEF; k++) begin
               sim_now += $urandom_range(0, 5);
               push_beat(OP_SLEEP, sim_now, $urandom_range(0, 300), SLOT_W'(k));
            end
            for (k = 0; k < 3; k++) begin
               sim_now += $urandom_range(0, 150);
               push_beat(OP_PICK, sim_now, $urandom, SLOT_W'($urandom_range(0, 7)));
            end
            made += MAX_SLOTS_DEF + 3;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40)
               op = OP_SLEEP;
            else if (r < 88)
               op = OP_PICK;
            else if (r < 94)
               op = OP_CREATE;
            else
               op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0) begin
               now_ms = $urandom;
            end else begin
               sim_now += $urandom_range(0, 40);
               now_ms = sim_now;
            end
            dur = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 300) : $urandom;
            push_beat(op, now_ms, dur, SLOT_W'($urandom_range(0, 7)));
            if (op != OP_UNUSED)
               made++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (req_valid && !req_stall) begin
         expected_results.push_back(predict_schedule(pending_beats.pop_front()));
         if (gap_left > 0 || pending_beats.size() == 0)
            req_valid <= 1'b0;
         else
            offer_front();
      end else if (!req_valid) begin
         if (gap_left > 0)
            gap_left--;
         else if (pending_beats.size() != 0)
            offer_front();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         // hold off long enough that the block backs up into its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = draw_idle();
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected beat status=%0d slot=%0d switch=%0b", $time,
                     rsp_status, rsp_thread_slot, rsp_switch_request);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_status);
               mismatches++;
            end
            if (rsp_thread_slot !== want.thread_slot) begin
               $display("%0t: thread_slot expected %0d actual %0d", $time,
                        want.thread_slot, rsp_thread_slot);
               mismatches++;
            end
            if (rsp_switch_request !== want.switch_request) begin
               $display("%0t: switch_request expected %0b actual %0b", $time,
                        want.switch_request, rsp_switch_request);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_beat(OP_PICK, 32'd0, 32'd0, 3'd0);
      push_beat(OP_SLEEP, 32'd0, 32'd0, 3'd7);
      push_beat(OP_UNUSED, '1, '1, '1);
      push_beat(OP_CREATE, '1, '1, '1);
      push_beat(OP_PICK, 32'd5, 32'd0, 3'd0);
      push_beat(OP_SLEEP, 32'd100, 32'd50, 3'd0);
      push_beat(OP_PICK, 32'd149, 32'd0, 3'd0);
      push_beat(OP_PICK, 32'd150, 32'd0, 3'd0);
      push_beat(OP_CREATE, 32'd160, 32'd0, 3'd0);
      push_beat(OP_CREATE, 32'd161, 32'd0, 3'd0);
      push_beat(OP_SLEEP, 32'd170, 32'd5, 3'd3);
      push_beat(OP_SLEEP, 32'hFFFF_FFF0, 32'h20, 3'd1);
      push_beat(OP_PICK, 32'h0000_000F, 32'd0, 3'd0);
      push_beat(OP_PICK, 32'h0000_0010, 32'd0, 3'd0);
      push_beat(OP_PICK, 32'h0000_0010, 32'd0, 3'd0);
      push_beat(OP_SLEEP, 32'd0, 32'hFFFF_FFFF, 3'd2);
      for (int k = 0; k < MAX_SLOTS_DEF - 3; k++)
         push_beat(OP_CREATE, 32'd200, 32'd0, 3'd0);
      push_beat(OP_CREATE, 32'd201, 32'd0, 3'd0);
      push_beat(OP_SLEEP, 32'd1000, 32'd0, 3'd7);
      push_beat(OP_PICK, 32'd1000, 32'd0, 3'd0);
      wait_drained();

      sim_now = 32'd2000;
      fill_random(300);
      wait_drained();
      fill_random(300);
      wait_drained();
      repeat (40) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

>>> sim.f
rtl/rrss_pkg.sv
rtl/rrss_alu.sv
rtl/round_robin_sleep_scheduler.sv
tb/sv/tb.sv
